FILE: design/sirr_pkg.sv
package sirr_pkg;

	// Field widths fixed by the word format
	localparam int SEQ_W  = 32;
	localparam int BYTE_W = 8;
	localparam int CNT_W  = 13;

	// Default ring size in bytes
	localparam int RING_BYTES_DEF = 4096;

	// Operation codes
	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_ACK   = 2'd1,
		OP_READ  = 2'd2,
		OP_SET   = 2'd3
	} op_t;

	// Status codes
	localparam logic ST_DONE    = 1'b0;
	localparam logic ST_REFUSED = 1'b1;

	// Command word
	typedef struct packed {
		op_t               operation;
		logic [BYTE_W-1:0] data_byte;
		logic [SEQ_W-1:0]  seq_number;
	} cmd_t;

	// Result word
	typedef struct packed {
		logic              status;
		logic [BYTE_W-1:0] read_byte;
		logic [CNT_W-1:0]  fill_count;
		logic [CNT_W-1:0]  available_back;
	} rsp_t;

endpackage

FILE: design/sequence_indexed_retransmit_ring_unit.sv
// Channel   Handshake              Word               Direction
// command   start / busy           item  (cmd_t)      in
// result    done (one-cycle pulse) result (rsp_t)     out
//
// A command passes from acceptance to the done pulse through these steps: latch,
// sequence distance, ring access with counter update, report. The ring
// memory port (one access per command) and the two 32-bit distance
// subtractions set these steps; a new command is taken in the cycle done shows.
// The receiver cannot stall: done is a single-cycle strobe.
// Reset clears the counters and sequence; ring contents stay undefined.
module sequence_indexed_retransmit_ring_unit #(
	parameter int RING_BYTES = sirr_pkg::RING_BYTES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  sirr_pkg::cmd_t item,
	output logic           done,
	output sirr_pkg::rsp_t result
);

	import sirr_pkg::*;

	localparam int PW = $clog2(RING_BYTES);
	localparam int HW = $clog2(RING_BYTES + 1);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_DIST = 4'b0010,
		S_EXEC = 4'b0100,
		S_FIN  = 4'b1000
	} state_t;

	state_t            state_q;
	cmd_t              cmd_q;
	logic [SEQ_W-1:0]  dist_q;
	logic [SEQ_W-1:0]  ws_q;
	logic [PW-1:0]     wp_q;
	logic [HW-1:0]     held_q;
	logic              status_q;
	logic              rd_ok_q;
	logic              done_q;
	rsp_t              result_q;

	logic              dist_neg;
	logic              dist_zero;
	logic [SEQ_W-1:0]  held_ext;
	logic              dist_lt_held;
	logic              dist_gt_held;
	logic              full;
	logic              rd_refuse;
	logic [PW-1:0]     wp_inc;
	logic [HW:0]       rd_diff;
	logic [PW-1:0]     rd_idx;
	logic              ram_we;
	logic [BYTE_W-1:0] ram_rdata;
	logic [SEQ_W-1:0]  fin_dist;
	logic [CNT_W-1:0]  fin_avail;

	// Decode the registered distance against the held count
	always_comb begin
		held_ext     = SEQ_W'(held_q);
		dist_neg     = dist_q[SEQ_W-1];
		dist_zero    = (dist_q == '0);
		dist_lt_held = (dist_q < held_ext);
		dist_gt_held = (dist_q > held_ext);
		full         = (held_q == HW'(RING_BYTES));
		rd_refuse    = dist_neg | dist_zero | dist_gt_held;
		wp_inc       = (wp_q == PW'(RING_BYTES - 1)) ? '0 : wp_q + 1'b1;
		// Wrap the read index back around the ring
		rd_diff      = (HW+1)'(wp_q) - (HW+1)'(dist_q[HW-1:0]);
		if (rd_diff[HW]) begin
			rd_idx = PW'(rd_diff + (HW+1)'(RING_BYTES));
		end else begin
			rd_idx = PW'(rd_diff);
		end
		ram_we = (state_q == S_EXEC) && (cmd_q.operation == OP_WRITE) && !full;
	end

	// Report distance from the updated write sequence
	always_comb begin
		fin_dist = ws_q - cmd_q.seq_number;
		if (fin_dist[SEQ_W-1] || (fin_dist > held_ext)) begin
			fin_avail = '0;
		end else begin
			fin_avail = CNT_W'(fin_dist);
		end
	end

	sirr_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (RING_BYTES)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wp_q),
		.wdata (cmd_q.data_byte),
		.raddr (rd_idx),
		.rdata (ram_rdata)
	);

	// Sequencer and ring counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ws_q    <= '0;
			wp_q    <= '0;
			held_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == S_FIN);
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_DIST;
					end
				end
				S_DIST: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					state_q <= S_FIN;
					unique case (cmd_q.operation)
						OP_WRITE: begin
							if (!full) begin
								wp_q   <= wp_inc;
								held_q <= held_q + 1'b1;
								ws_q   <= ws_q + 1'b1;
							end
						end
						OP_ACK: begin
							// Drop older bytes; empty the ring when nothing is left
							if (dist_neg || dist_zero) begin
								held_q <= '0;
								ws_q   <= cmd_q.seq_number;
							end else if (dist_lt_held) begin
								held_q <= HW'(dist_q);
							end
							if (dist_neg || dist_zero || (held_q == '0)) begin
								wp_q <= '0;
							end
						end
						OP_READ: begin
						end
						OP_SET: begin
							ws_q <= cmd_q.seq_number;
						end
					endcase
				end
				S_FIN: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && start) begin
			cmd_q <= item;
		end
		if (state_q == S_DIST) begin
			dist_q <= ws_q - cmd_q.seq_number;
		end
		if (state_q == S_EXEC) begin
			// Refuse a write to a full ring or a read of a byte not held
			status_q <= (((cmd_q.operation == OP_WRITE) && full) ||
				((cmd_q.operation == OP_READ) && rd_refuse)) ? ST_REFUSED : ST_DONE;
			rd_ok_q  <= (cmd_q.operation == OP_READ) && !rd_refuse;
		end
		if (state_q == S_FIN) begin
			result_q.status         <= status_q;
			result_q.read_byte      <= rd_ok_q ? ram_rdata : '0;
			result_q.fill_count     <= CNT_W'(held_q);
			result_q.available_back <= fin_avail;
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

FILE: design/sirr_ram.sv
module sirr_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 4096,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: design/sirr_chk.sv
module sirr_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input sirr_pkg::rsp_t result
);

	import sirr_pkg::*;

	// A result shows only while no command is in flight
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	// An accepted command is answered with a done pulse
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##4 done)
		else $error("result missing");

	// Strobe lasts one cycle
	a_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done longer than one cycle");

	// A refused word carries no byte
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status == ST_REFUSED)) |-> (result.read_byte == '0))
		else $error("byte on refused result");

endmodule

bind sequence_indexed_retransmit_ring_unit sirr_chk u_sirr_chk (.*);

FILE: tb/sv/sequence_indexed_retransmit_ring_unit_test.sv
`timescale 1ns / 100ps

module sequence_indexed_retransmit_ring_unit_test;
	import sirr_pkg::*;

	localparam int RING         = RING_BYTES_DEF;
	localparam int RANDOM_WORDS = 1850;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int REPORT_MAX   = 10;

	// Track ring state and the result words it should produce
	class retransmit_ring_checker;
		logic [7:0]  ring_bytes [RING];
		int unsigned next_pos;
		logic [31:0] next_seq;
		int unsigned held;
		rsp_t        pending_reports [$];
		int          failures;

		function new();
			next_pos = 0;
			next_seq = '0;
			held     = 0;
			failures = 0;
		endfunction

		// Apply one command word to the ring copy and form its report
		function rsp_t predict_report(cmd_t c);
			rsp_t        rep;
			logic [31:0] span;
			bit          ahead;
			rep   = '0;
			span  = next_seq - c.seq_number;
			ahead = span[31];
			case (c.operation)
			OP_WRITE: begin
				if (held >= RING) begin
					rep.status = ST_REFUSED;
				end else begin
					ring_bytes[next_pos] = c.data_byte;
					next_pos = (next_pos + 1) % RING;
					held++;
					next_seq++;
				end
			end
			OP_ACK: begin
				// A sequence at or ahead of the write point empties the ring
				if (ahead || span == 0) begin
					held     = 0;
					next_seq = c.seq_number;
				end else if (span < held) begin
					held = span;
				end
				if (held == 0)
					next_pos = 0;
			end
			OP_READ: begin
				if (ahead || span == 0 || span > held)
					rep.status = ST_REFUSED;
				else
					rep.read_byte = ring_bytes[(next_pos + RING - span) % RING];
			end
			OP_SET: begin
				next_seq = c.seq_number;
			end
			endcase
			// Report fill and reach back from the given sequence after the update
			span = next_seq - c.seq_number;
			rep.fill_count     = CNT_W'(held);
			rep.available_back = (span[31] || span > held) ? '0 : span[CNT_W-1:0];
			return rep;
		endfunction

		function void note_command(cmd_t c);
			pending_reports.push_back(predict_report(c));
		endfunction

		// Compare a result word with the oldest pending report
		function void check_result(rsp_t got);
			rsp_t want;
			if (pending_reports.size() == 0) begin
				failures++;
				if (failures <= REPORT_MAX)
					$display("result word with none pending: st=%0d rb=%02h fill=%0d avail=%0d",
						got.status, got.read_byte, got.fill_count, got.available_back);
				return;
			end
			want = pending_reports.pop_front();
			if (got.status !== want.status || got.read_byte !== want.read_byte ||
				got.fill_count !== want.fill_count ||
				got.available_back !== want.available_back) begin
				failures++;
				if (failures <= REPORT_MAX)
					$display({"mismatch: want st=%0d rb=%02h fill=%0d avail=%0d, ",
						"got st=%0d rb=%02h fill=%0d avail=%0d"},
						want.status, want.read_byte, want.fill_count, want.available_back,
						got.status, got.read_byte, got.fill_count, got.available_back);
			end
		endfunction

		function int pending();
			return pending_reports.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	cmd_t item;
	rsp_t result;

	int cycle_count = 0;
	int burst_left  = 10;

	retransmit_ring_checker ring_check = new();

	sequence_indexed_retransmit_ring_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Abandon the run if it hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("sequence_indexed_retransmit_ring_unit_test: errors");
			$finish;
		end
	end

	// Collect result words on the strobe
	always @(posedge clk) begin
		if (arst_n && done)
			ring_check.check_result(result);
	end

	function automatic cmd_t cmd_word(op_t op, logic [7:0] data, logic [31:0] seq);
		cmd_t c;
		c.operation  = op;
		c.data_byte  = data;
		c.seq_number = seq;
		return c;
	endfunction

	// Offer one word, hold it until taken, then pace the next burst
	task automatic send_word(input cmd_t c);
		start <= 1'b1;
		item  <= c;
		do @(posedge clk); while (busy);
		ring_check.note_command(c);
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
			                                         : $urandom_range(1, 12);
		end
	endtask

	// Mostly well-formed traffic aimed at held bytes, with some noise
	function automatic cmd_t random_command();
		cmd_t        c;
		int unsigned pick;
		int unsigned reach;
		int unsigned trim;
		c.operation  = OP_WRITE;
		c.data_byte  = 8'($urandom_range(0, 255));
		c.seq_number = $urandom;
		pick  = $urandom_range(0, 99);
		reach = ring_check.held + 2;
		trim  = (ring_check.held < 8) ? ring_check.held : 8;
		if (pick < 40) begin
			c.operation = OP_WRITE;
		end else if (pick < 62) begin
			c.operation  = OP_READ;
			c.seq_number = ring_check.next_seq - $urandom_range(0, reach);
		end else if (pick < 68) begin
			c.operation  = OP_ACK;
			c.seq_number = ring_check.next_seq - $urandom_range(0, reach);
		end else if (pick < 74) begin
			// Drop only a few of the oldest bytes
			c.operation  = OP_ACK;
			c.seq_number = ring_check.next_seq - (ring_check.held - $urandom_range(0, trim));
		end else if (pick < 78) begin
			c.operation = OP_SET;
			case ($urandom_range(0, 2))
			0: c.seq_number = $urandom;
			1: c.seq_number = 32'hFFFF_FFFF - $urandom_range(0, 16);
			default: c.seq_number = 32'h7FFF_FFFF - $urandom_range(0, 16);
			endcase
		end else begin
			c.operation = op_t'($urandom_range(0, 3));
		end
		return c;
	endfunction

	initial begin
		arst_n <= 1'b0;
		start  <= 1'b0;
		item   <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty ring: read and acknowledge at the write point
		send_word(cmd_word(OP_READ,  8'h00, 32'h0000_0000));
		send_word(cmd_word(OP_ACK,   8'hFF, 32'h0000_0000));
		// Write across the 32-bit sequence wrap
		send_word(cmd_word(OP_SET,   8'h00, 32'hFFFF_FFFE));
		send_word(cmd_word(OP_WRITE, 8'h00, 32'h0000_0000));
		send_word(cmd_word(OP_WRITE, 8'hFF, 32'hFFFF_FFFF));
		send_word(cmd_word(OP_WRITE, 8'hA5, 32'h1234_5678));
		// Reads of held bytes, the write point, behind and ahead
		send_word(cmd_word(OP_READ,  8'h00, 32'hFFFF_FFFE));
		send_word(cmd_word(OP_READ,  8'h00, 32'hFFFF_FFFF));
		send_word(cmd_word(OP_READ,  8'hFF, 32'h0000_0000));
		send_word(cmd_word(OP_READ,  8'h00, 32'h0000_0001));
		send_word(cmd_word(OP_READ,  8'h00, 32'hFFFF_FFFD));
		send_word(cmd_word(OP_READ,  8'h00, 32'h0000_0005));
		// Largest positive distance, then the first negative one
		send_word(cmd_word(OP_READ,  8'h00, 32'h8000_0002));
		send_word(cmd_word(OP_READ,  8'h00, 32'h8000_0001));
		// Acknowledge behind held data, then drop one byte
		send_word(cmd_word(OP_ACK,   8'h00, 32'hFFFF_FFF0));
		send_word(cmd_word(OP_ACK,   8'h00, 32'hFFFF_FFFF));
		// Set keeps the held bytes
		send_word(cmd_word(OP_SET,   8'hFF, 32'h1234_5678));
		send_word(cmd_word(OP_READ,  8'h00, 32'h1234_5676));
		// Acknowledge ahead, then at the write point
		send_word(cmd_word(OP_ACK,   8'h00, 32'h1234_5680));
		send_word(cmd_word(OP_WRITE, 8'h5A, 32'hFFFF_FFFF));
		send_word(cmd_word(OP_ACK,   8'h00, 32'h1234_5681));
		send_word(cmd_word(OP_SET,   8'hFF, 32'hFFFF_FFFF));
		send_word(cmd_word(OP_WRITE, 8'h81, 32'h0000_0000));
		send_word(cmd_word(OP_READ,  8'h00, 32'hFFFF_FFFF));

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i == RANDOM_WORDS / 2) begin
				// Empty, fill to the brim, push past full, probe and drain half
				send_word(cmd_word(OP_ACK, 8'h00, ring_check.next_seq));
				while (ring_check.held < RING)
					send_word(cmd_word(OP_WRITE, 8'($urandom_range(0, 255)), $urandom));
				repeat (3)
					send_word(cmd_word(OP_WRITE, 8'($urandom_range(0, 255)), $urandom));
				send_word(cmd_word(OP_READ, 8'h00, ring_check.next_seq - RING));
				send_word(cmd_word(OP_READ, 8'h00, ring_check.next_seq - RING - 1));
				send_word(cmd_word(OP_READ, 8'h00, ring_check.next_seq - 1));
				send_word(cmd_word(OP_ACK,  8'h00, ring_check.next_seq - RING));
				send_word(cmd_word(OP_ACK,  8'h00, ring_check.next_seq - RING / 2));
			end
			send_word(random_command());
		end
		start <= 1'b0;

		// Drain outstanding results, then allow for stray strobes
		while (ring_check.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (ring_check.failures == 0 && ring_check.pending() == 0)
			$display("sequence_indexed_retransmit_ring_unit_test: clean");
		else
			$display("sequence_indexed_retransmit_ring_unit_test: errors");
		$finish;
	end

endmodule
